@@ design/dcwm_pkg.sv @@
// Shared constants, types and helpers of the dark channel window minimum block.
`timescale 1ns / 1ps
package dcwm_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxRadius = 7;
  localparam int WinDepth  = 2 * MaxRadius + 1;
  localparam int LineRows  = 2 * MaxRadius;
  localparam int LineW     = LineRows * 8;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int DimW      = 12;
  localparam int RadW      = 3;
  localparam int SpanW     = $clog2(WinDepth + 1);
  localparam int CfgIdxW   = 2;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = QPtrW + 1;

  localparam logic [7:0]      PixMax   = 8'hFF;
  localparam logic [DimW-1:0] DimLimit = DimW'(MaxWidth);

  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [7:0]       hmin;
    logic [SpanW-1:0] nprev;
    logic             emit;
    logic             last;
  } task_t;

  typedef struct packed {
    logic [7:0] dark;
    logic       last;
  } result_t;

  function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
    min8 = (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] min16(input logic [15:0][7:0] v);
    logic [7:0][7:0] l1;
    logic [3:0][7:0] l2;
    logic [1:0][7:0] l3;
    for (int i = 0; i < 8; i++) l1[i] = min8(v[2*i], v[2*i+1]);
    for (int i = 0; i < 4; i++) l2[i] = min8(l1[2*i], l1[2*i+1]);
    for (int i = 0; i < 2; i++) l3[i] = min8(l2[2*i], l2[2*i+1]);
    min16 = min8(l3[0], l3[1]);
  endfunction

endpackage

@@ design/dcwm_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module dcwm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dcwm_front.sv @@
// Front end: configuration, raster position, row window and per-column work generation.
`timescale 1ns / 1ps
module dcwm_front import dcwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic               command_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  output logic               task_push_o,
  output task_t              task_o,
  input  logic               task_full_i
);

  logic [RadW-1:0] radius_q;
  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] w_eff, h_eff, wm1;
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [DimW-1:0] in_row_q, in_row_d;
  logic [7:0]      win_q [WinDepth];
  logic [7:0]      win_d [WinDepth];
  logic            pend_q, pend_d;
  logic [ColW-1:0] cur_q, cur_d, hi_q, hi_d, base_q, base_d;
  logic [DimW-1:0] row_q, row_d;
  logic            accept, restart, col_end, any, issue, issue_last;
  logic [ColW-1:0] lo;
  logic [7:0]      pm;
  logic [SpanW-1:0] span;
  logic [ColW-1:0] diff;
  logic [15:0][7:0] masked;
  logic [DimW:0]   row_inc, row_lim;

  assign cfg_ready_o = 1'b1;
  assign restart = cfg_valid_i && (cfg_index_i == CfgRadius || cfg_index_i == CfgWidth ||
                                   cfg_index_i == CfgHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(7);
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRadius: radius_q <= cfg_data_i[RadW-1:0];
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_q == '0) ? DimW'(1) : ((width_q > DimLimit) ? DimLimit : width_q);
    h_eff = (height_q == '0) ? DimW'(1) : ((height_q > DimLimit) ? DimLimit : height_q);
    wm1   = w_eff - DimW'(1);
  end

  assign issue      = pend_q && !task_full_i;
  assign issue_last = issue && (cur_q == hi_q);
  assign full_o     = pend_q && !issue_last;
  assign accept     = push_i && !full_o;

  always_comb begin
    pm = PixMax;
    if (!command_i && in_row_q < h_eff) begin
      pm = min8(min8(blue_i, green_i), red_i);
    end
    col_end = ({1'b0, in_col_q} == wm1);
    any     = col_end || (in_col_q >= ColW'(radius_q));
    lo      = (in_col_q >= ColW'(radius_q)) ? in_col_q - ColW'(radius_q) : '0;
    row_inc = {1'b0, in_row_q} + (DimW+1)'(1);
    row_lim = {1'b0, h_eff} + (DimW+1)'(radius_q);
  end

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    win_d    = win_q;
    pend_d   = pend_q;
    cur_d    = cur_q;
    hi_d     = hi_q;
    base_d   = base_q;
    row_d    = row_q;
    if (issue) begin
      if (issue_last) begin
        pend_d = 1'b0;
      end else begin
        cur_d = cur_q + ColW'(1);
      end
    end
    if (accept) begin
      win_d[0] = pm;
      for (int i = 1; i < WinDepth; i++) begin
        win_d[i] = (in_col_q == '0) ? PixMax : win_q[i-1];
      end
      pend_d = any;
      cur_d  = lo;
      hi_d   = col_end ? in_col_q : lo;
      base_d = in_col_q;
      row_d  = in_row_q;
      if (col_end) begin
        in_col_d = '0;
        in_row_d = (row_inc >= row_lim) ? '0 : row_inc[DimW-1:0];
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end
    if (restart) begin
      in_col_d = '0;
      in_row_d = '0;
      pend_d   = 1'b0;
      for (int i = 0; i < WinDepth; i++) win_d[i] = PixMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      pend_q   <= 1'b0;
      for (int i = 0; i < WinDepth; i++) win_q[i] <= PixMax;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      pend_q   <= pend_d;
      win_q    <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    hi_q   <= hi_d;
    base_q <= base_d;
    row_q  <= row_d;
  end

  always_comb begin
    diff = base_q - cur_q;
    span = SpanW'(diff[RadW:0]) + SpanW'(radius_q);
    for (int i = 0; i < 16; i++) begin
      masked[i] = (i < WinDepth && SpanW'(i) <= span) ? win_q[i % WinDepth] : PixMax;
    end
    task_o.col   = cur_q;
    task_o.hmin  = min16(masked);
    task_o.nprev = (row_q < DimW'({radius_q, 1'b0})) ? SpanW'(row_q[RadW:0])
                                                      : SpanW'({radius_q, 1'b0});
    task_o.emit  = (row_q >= DimW'(radius_q));
    task_o.last  = ({1'b0, row_q} == row_lim - (DimW+1)'(1)) && ({1'b0, cur_q} == wm1);
  end

  assign task_push_o = issue;

endmodule

@@ design/dcwm_task_queue.sv @@
// Short queue of column tasks between front and back.
`timescale 1ns / 1ps
module dcwm_task_queue import dcwm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output task_t data_o,
  output logic  empty_o
);

  task_t            mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

endmodule

@@ design/dcwm_back.sv @@
// Back end: column line buffer update, vertical minimum and result queue.
`timescale 1ns / 1ps
module dcwm_back import dcwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       task_empty_i,
  input  task_t      task_i,
  output logic       task_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] dark_value_o,
  output logic       frame_last_o
);

  logic             s1_v_q, s1_fwd_q;
  task_t            s1_task_q;
  logic [LineW-1:0] rdata, old_word, new_word, wr_q;
  logic [15:0][7:0] masked;
  logic [7:0]       vmin;
  result_t          res_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             res_push, res_pop;
  logic [QCntW:0]   used;

  assign used       = {1'b0, cnt_q} + (QCntW+1)'(s1_v_q);
  assign task_pop_o = !task_empty_i && (used < (QCntW+1)'(QDepth));

  dcwm_ram #(
    .Width(LineW),
    .Depth(MaxWidth)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (s1_v_q),
    .waddr_i(s1_task_q.col),
    .wdata_i(new_word),
    .raddr_i(task_i.col),
    .rdata_o(rdata)
  );

  always_comb begin
    old_word  = s1_fwd_q ? wr_q : rdata;
    new_word  = {old_word[LineW-9:0], s1_task_q.hmin};
    masked[0] = s1_task_q.hmin;
    for (int k = 1; k < 16; k++) begin
      masked[k] = (k <= LineRows && SpanW'(k) <= s1_task_q.nprev)
                  ? old_word[((k-1) % LineRows)*8 +: 8] : PixMax;
    end
    vmin = min16(masked);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= task_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_task_q <= task_i;
    s1_fwd_q  <= s1_v_q && (s1_task_q.col == task_i.col);
    if (s1_v_q) begin
      wr_q <= new_word;
    end
  end

  assign res_push = s1_v_q && s1_task_q.emit;
  assign res_pop  = pop_i && !empty_o;
  assign empty_o  = (cnt_q == '0);
  assign dark_value_o = res_q[rptr_q].dark;
  assign frame_last_o = res_q[rptr_q].last;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wptr_q] <= '{dark: vmin, last: s1_task_q.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (res_push) wptr_q <= wptr_q + QPtrW'(1);
      if (res_pop)  rptr_q <= rptr_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(res_push) - QCntW'(res_pop);
    end
  end

endmodule

@@ design/dark_channel_window_min.sv @@
// Top level of the dark channel window minimum filter.
// Input queue side: push/full move one raster word (command, blue, green, red).
// Output queue side: empty/pop expose the oldest result (dark_value, frame_last).
// Config: cfg_valid_i/cfg_ready_o write radius (0), frame_width (1), frame_height (2);
// any known write restarts the frame at position (0,0). Write only while idle.
// Each frame is (H+R)*W words; the last R rows are drain words (command 1).
// One word per cycle unless full; a row-end word issues up to R+1 column tasks,
// holding full until the last issues. The front issues one task per cycle into the
// four-entry task queue unless it is full; the back does one read-modify-write
// of the line buffer per cycle (one 112-bit RAM word per column) unless the result
// queue is full. Results are registered in front, task queue, back and result queue.
// A stalled receiver fills the four-entry result queue, then the task queue,
// then full rises; nothing is dropped.
// Reset clears position, row window and queues; radius 7, 640x480.
// The line buffer needs no clearing: rows from before a restart are never read.
`timescale 1ns / 1ps
module dark_channel_window_min import dcwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               command_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         dark_value_o,
  output logic               frame_last_o
);

  task_t t_in, t_out;
  logic  t_push, t_full, t_pop, t_empty;

  dcwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_o     (full),
    .command_i  (command_i),
    .blue_i     (blue_i),
    .green_i    (green_i),
    .red_i      (red_i),
    .task_push_o(t_push),
    .task_o     (t_in),
    .task_full_i(t_full)
  );

  dcwm_task_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (t_push),
    .data_i (t_in),
    .full_o (t_full),
    .pop_i  (t_pop),
    .data_o (t_out),
    .empty_o(t_empty)
  );

  dcwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .task_empty_i(t_empty),
    .task_i      (t_out),
    .task_pop_o  (t_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .dark_value_o(dark_value_o),
    .frame_last_o(frame_last_o)
  );

endmodule

@@ design/dcwm_checker.sv @@
// Port level checker of the dark channel window minimum filter and its bind.
`timescale 1ns / 1ps
module dcwm_checker import dcwm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] dark_value_o,
  input logic       frame_last_o
);

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not idle after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(dark_value_o) && $stable(frame_last_o)))
    else $error("waiting result changed");

endmodule

bind dark_channel_window_min dcwm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .dark_value_o(dark_value_o),
  .frame_last_o(frame_last_o)
);

@@ test/dark_channel_window_min_tb.sv @@
// Testbench for the dark channel window minimum filter: directed and random frames.
`timescale 1ns / 1ps
module dark_channel_window_min_tb;
  import dcwm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnknown = 2'd3;
  localparam int StallLimit = 5000;
  localparam int SettleCycles = 10;

  typedef struct packed {
    logic [7:0] dark;
    logic       last;
  } dark_word_t;

  typedef struct {
    logic       cmd;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       typed;
    logic [7:0] dark;
    logic       last;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DimW-1:0]    cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic               command_i = 1'b0;
  logic [7:0]         blue_i = '0;
  logic [7:0]         green_i = '0;
  logic [7:0]         red_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         dark_value_o;
  logic               frame_last_o;

  dark_channel_window_min dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  dark_word_t  expected_dark[$];
  logic [7:0]  line_mem [0:LineRows*MaxWidth-1];
  logic [7:0]  row_win [0:WinDepth-1];
  int          pos_row, pos_col;
  int          cfg_radius, cfg_width, cfg_height;
  int          errors = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  function automatic int eff_width();
    return cfg_width < 1 ? 1 : (cfg_width > MaxWidth ? MaxWidth : cfg_width);
  endfunction

  function automatic int eff_height();
    return cfg_height < 1 ? 1 : (cfg_height > MaxWidth ? MaxWidth : cfg_height);
  endfunction

  function automatic void restart_frame();
    pos_row = 0;
    pos_col = 0;
    foreach (row_win[i]) row_win[i] = 8'hFF;
  endfunction

  function automatic void predict_word(input logic cmd, input logic [7:0] b,
                                       input logic [7:0] g, input logic [7:0] r);
    int rad, w, h, lines, lo, hi, span, slot;
    logic [7:0] pm, hmin, vmin;
    bit any;
    dark_word_t e;
    rad = cfg_radius;
    w = eff_width();
    h = eff_height();
    lines = 2 * rad;
    pm = 8'hFF;
    any = 1'b0;
    lo = 0;
    hi = 0;
    if (!cmd && pos_row < h) begin
      pm = b;
      if (g < pm) pm = g;
      if (r < pm) pm = r;
    end
    if (pos_col == 0) foreach (row_win[i]) row_win[i] = 8'hFF;
    for (int i = WinDepth - 1; i > 0; i--) row_win[i] = row_win[i-1];
    row_win[0] = pm;
    if (pos_col == w - 1) begin
      lo = pos_col >= rad ? pos_col - rad : 0;
      hi = w - 1;
      any = 1'b1;
    end else if (pos_col >= rad) begin
      lo = pos_col - rad;
      hi = lo;
      any = 1'b1;
    end
    if (any) begin
      for (int c = lo; c <= hi; c++) begin
        span = pos_col - c + rad;
        hmin = 8'hFF;
        for (int i = 0; i <= span && i < WinDepth; i++) begin
          if (row_win[i] < hmin) hmin = row_win[i];
        end
        vmin = hmin;
        for (int k = 1; k <= lines; k++) begin
          if (pos_row >= k) begin
            slot = (pos_row - k) % lines;
            if (line_mem[slot*MaxWidth+c] < vmin) vmin = line_mem[slot*MaxWidth+c];
          end
        end
        if (lines > 0) line_mem[(pos_row % lines)*MaxWidth+c] = hmin;
        if (pos_row >= rad) begin
          e.dark = vmin;
          e.last = (pos_row - rad == h - 1) && (c == w - 1);
          expected_dark.push_back(e);
        end
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h + rad) pos_row = 0;
    end
  endfunction

  // check results, drive pop, guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        words_out++;
        if (expected_dark.size() == 0) begin
          $error("result word with nothing expected: dark_value %0d", dark_value_o);
          errors++;
        end else begin
          if (dark_value_o !== expected_dark[0].dark) begin
            $error("dark_value expected %0d got %0d", expected_dark[0].dark, dark_value_o);
            errors++;
          end
          if (frame_last_o !== expected_dark[0].last) begin
            $error("frame_last expected %0d got %0d", expected_dark[0].last, frame_last_o);
            errors++;
          end
          void'(expected_dark.pop_front());
        end
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("dark_channel_window_min test failed");
        $finish;
      end
    end
    pop <= quiet || ($urandom_range(99) >= 32);
  end

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_dark.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgRadius: cfg_radius = int'(data[RadW-1:0]);
      CfgWidth:  cfg_width = int'(data);
      CfgHeight: cfg_height = int'(data);
      default: ;
    endcase
    if (idx != CfgUnknown) restart_frame();
  endtask

  task automatic send_word(input logic cmd, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r);
    while (!quiet && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    blue_i <= b;
    green_i <= g;
    red_i <= r;
    do @(posedge clk_i); while (full);
    words_in++;
    predict_word(cmd, b, g, r);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  stim_row_t table_rows[7] = '{
    '{1'b0, 8'h00, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0},
    '{1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{1'b0, 8'hFF, 8'hFF, 8'h07, 1'b1, 8'h07, 1'b0},
    '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0},
    '{1'b0, 8'h03, 8'h02, 8'h01, 1'b1, 8'h01, 1'b1},
    '{1'b0, 8'h80, 8'h40, 8'h20, 1'b0, 8'h00, 1'b0}
  };

  initial begin
    int n, len, random_words, phase, hgt;
    logic cmd;
    cfg_radius = 7;
    cfg_width = 640;
    cfg_height = 480;
    restart_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_reg(CfgRadius, 12'd0);
    set_reg(CfgWidth, 12'd3);
    set_reg(CfgHeight, 12'd2);
    foreach (table_rows[i]) begin
      send_word(table_rows[i].cmd, table_rows[i].b, table_rows[i].g, table_rows[i].r);
      if (table_rows[i].typed) begin
        expected_dark[expected_dark.size()-1].dark = table_rows[i].dark;
        expected_dark[expected_dark.size()-1].last = table_rows[i].last;
      end
    end

    // widest window on a tiny frame, drain rows fed with mismatched commands
    set_reg(CfgRadius, 12'd7);
    set_reg(CfgWidth, 12'd2);
    set_reg(CfgHeight, 12'd1);
    for (int i = 0; i < 16; i++) begin
      if (i == 8) wait_drained();
      send_word(i[0], rand_chan(), rand_chan(), rand_chan());
    end

    // widest and tallest frame, clamped, first few words
    set_reg(CfgRadius, 12'd0);
    set_reg(CfgWidth, 12'hFFF);
    set_reg(CfgHeight, 12'hFFF);
    for (int i = 0; i < 12; i++) send_word(1'b0, rand_chan(), rand_chan(), rand_chan());
    set_reg(CfgUnknown, 12'hABC);
    for (int i = 0; i < 4; i++) send_word(1'b0, rand_chan(), rand_chan(), rand_chan());

    random_words = 0;
    phase = 0;
    while (random_words < 320) begin
      phase++;
      if ($urandom_range(5) == 0) set_reg(CfgUnknown, 12'($urandom));
      set_reg(CfgRadius, phase == 1 ? 12'd7 : (phase == 2 ? 12'd0 : 12'($urandom_range(7))));
      case ($urandom_range(9))
        0: set_reg(CfgWidth, 12'd0);
        1: set_reg(CfgWidth, 12'd1);
        default: set_reg(CfgWidth, 12'($urandom_range(2, 12)));
      endcase
      case ($urandom_range(11))
        0: set_reg(CfgHeight, 12'd0);
        1: set_reg(CfgHeight, 12'hFFF);
        default: set_reg(CfgHeight, 12'($urandom_range(1, 8)));
      endcase
      hgt = eff_height();
      len = (hgt + cfg_radius) * eff_width();
      case ($urandom_range(5))
        0: n = $urandom_range(1, len);
        1: n = len + $urandom_range(1, len);
        default: n = len;
      endcase
      if (n > 200) n = 40;
      for (int j = 0; j < n && random_words < 320; j++) begin
        if (phase == 5 && j == n / 2) wait_drained();
        quiet = (random_words >= 120 && random_words < 200);
        cmd = (pos_row >= hgt);
        if ($urandom_range(15) == 0) cmd = ~cmd;
        send_word(cmd, rand_chan(), rand_chan(), rand_chan());
        random_words++;
      end
    end
    quiet = 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d input words and %0d result words over %0d random frame setups",
             words_in, words_out, phase);
    if (errors == 0) begin
      $display("dark_channel_window_min test passed");
    end else begin
      $display("dark_channel_window_min test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/dcwm_pkg.sv
design/dcwm_ram.sv
design/dcwm_front.sv
design/dcwm_task_queue.sv
design/dcwm_back.sv
design/dark_channel_window_min.sv
design/dcwm_checker.sv
test/dark_channel_window_min_tb.sv
